FILE: hdl/hvn_pkg.sv
// Shared types and constants for the heightmap vertex normal block.
`default_nettype none
package hvn_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_SQ,
        ST_NSTART,
        ST_NWAIT,
        ST_OUT
    } state_t;

    // Component being squared or normalized.
    typedef enum logic [1:0] {
        COMP_X,
        COMP_Y,
        COMP_Z
    } comp_t;

    // Configuration register indexes.
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    localparam int CFG_W    = 11;
    localparam int SAMPLE_W = 8;
    localparam int MAG_W    = 11;
    localparam int SUMSQ_W  = 22;
    localparam int UNIT_W   = 16;
    localparam int COORD_W  = 10;

    // Read sequence of the stored samples around the current vertex.
    localparam logic [2:0] RD_PREV_C   = 3'd0;
    localparam logic [2:0] RD_PREV_CP  = 3'd1;
    localparam logic [2:0] RD_PREV2_C  = 3'd2;
    localparam logic [2:0] RD_PREV2_CP = 3'd3;
    localparam logic [2:0] RD_PREV_CM  = 3'd4;
    localparam logic [2:0] RD_PREV2_CM = 3'd5;
    localparam logic [2:0] RD_CUR_CM   = 3'd6;
    localparam logic [2:0] RD_DONE     = 3'd7;

    // Handshake between the sequencer and the normalizer.
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [UNIT_W-1:0]   result;
    } norm_status_t;

endpackage
`default_nettype wire

FILE: hdl/heightmap_vertex_normals.sv
// Flow per item: store reads, face sum, 3 squares, then per component a normalizer start
// and its bit-serial run, then the output load. Throughput: one sample per cycle when no normal
// is due; otherwise no new sample is taken until the word is loaded, set by the bit-serial
// normalizer that serves the three components in turn; a held output word stalls.
// Reset (aresetn, synchronous, active low) clears counters, sequencer and output valid;
// map_width and map_height return to 1024. The line store is not cleared.
`default_nettype none
module heightmap_vertex_normals
    import hvn_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire                        cfg_wr_index,
    input  wire [CFG_W-1:0]            cfg_wr_data,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire [SAMPLE_W-1:0]         s_height_sample,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic signed [15:0]         m_normal_x,
    output logic [14:0]                m_normal_y,
    output logic signed [15:0]         m_normal_z,
    output logic [COORD_W-1:0]         m_vertex_column,
    output logic [COORD_W-1:0]         m_vertex_row
);

    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    map_width_reg, map_height_reg;
    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic [1:0]          slot_reg;
    logic [12:0]         eff_w, eff_h;
    logic                accept;
    logic                emit;
    logic                last_col;

    // Per-item latched context.
    logic [CW-1:0]       item_col_reg;
    logic [RW-1:0]       item_row_reg;
    logic [1:0]          item_slot_reg;
    logic                item_c1_reg;
    logic                item_r2_reg;
    logic [SAMPLE_W-1:0] cur_sample_reg;
    logic [2:0]          rd_idx_reg;
    logic [SAMPLE_W-1:0] vals_reg [7];

    logic signed [11:0]  x_reg, z_reg;
    logic signed [11:0]  sum_x, sum_z;
    logic [5:0]          y_reg;
    logic [SUMSQ_W-1:0]  s_reg;
    comp_t               comp_reg;
    logic [MAG_W-1:0]    mag_sel;

    logic signed [15:0]  res_x_reg, res_z_reg;
    logic [14:0]         res_y_reg;
    logic                m_valid_reg;

    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [AW-1:0]       mem_wr_addr;
    logic [SAMPLE_W-1:0] mem_rd_data;
    logic                norm_start;
    norm_status_t        norm_status;

    // Effective dimensions, clamped to the supported range.
    always_comb begin
        if (map_width_reg < 11'd2)                        eff_w = 13'd2;
        else if (13'(map_width_reg) > 13'(MAX_WIDTH))     eff_w = 13'(MAX_WIDTH);
        else                                              eff_w = 13'(map_width_reg);
        if (map_height_reg < 11'd2)                       eff_h = 13'd2;
        else if (13'(map_height_reg) > 13'(MAX_HEIGHT))   eff_h = 13'(MAX_HEIGHT);
        else                                              eff_h = 13'(map_height_reg);
    end

    assign accept   = s_valid && s_ready;
    assign last_col = (13'(col_reg) + 13'd1) >= eff_w;
    assign emit     = (row_reg != '0) && !last_col;

    // Base address of a row slot.
    function automatic logic [AW-1:0] slot_base(input logic [1:0] slot);
        logic [AW-1:0] b;
        b = '0;
        case (slot)
            2'd1:    b = AW'(MAX_WIDTH);
            2'd2:    b = AW'(2 * MAX_WIDTH);
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] slot_add(input logic [1:0] slot, input logic [1:0] inc);
        logic [2:0] t;
        t = 3'(slot) + 3'(inc);
        return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= 11'd1024;
            map_height_reg <= 11'd1024;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_wr_data;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_wr_data;
                default:        ;
            endcase
        end
    end

    // Raster position counters and the row slot of the current row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else if (accept) begin
            if (last_col) begin
                col_reg <= '0;
                if ((13'(row_reg) + 13'd1) >= eff_h) begin
                    row_reg  <= '0;
                    slot_reg <= '0;
                end else begin
                    row_reg  <= row_reg + RW'(1);
                    slot_reg <= slot_add(slot_reg, 2'd1);
                end
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    assign mem_wr_addr = slot_base(slot_reg) + AW'(col_reg);

    hvn_line_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (mem_wr_addr),
        .wr_data (s_height_sample),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Read address for each step of the gather sequence.
    always_comb begin
        logic [1:0]    prev_slot, prev2_slot, slot;
        logic [CW-1:0] col;
        prev_slot  = slot_add(item_slot_reg, 2'd2);
        prev2_slot = slot_add(item_slot_reg, 2'd1);
        slot = prev_slot;
        col  = item_col_reg;
        case (rd_idx_reg)
            RD_PREV_C:   begin slot = prev_slot;     col = item_col_reg; end
            RD_PREV_CP:  begin slot = prev_slot;     col = item_col_reg + CW'(1); end
            RD_PREV2_C:  begin slot = prev2_slot;    col = item_col_reg; end
            RD_PREV2_CP: begin slot = prev2_slot;    col = item_col_reg + CW'(1); end
            RD_PREV_CM:  begin slot = prev_slot;     col = item_col_reg - CW'(item_c1_reg); end
            RD_PREV2_CM: begin slot = prev2_slot;    col = item_col_reg - CW'(item_c1_reg); end
            RD_CUR_CM:   begin slot = item_slot_reg; col = item_col_reg - CW'(item_c1_reg); end
            default:     begin slot = prev_slot;     col = item_col_reg; end
        endcase
        mem_rd_addr = slot_base(slot) + AW'(col);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && emit) state_next = ST_READ;
            ST_READ:   if (rd_idx_reg == RD_DONE) state_next = ST_SUM;
            ST_SUM:    state_next = ST_SQ;
            ST_SQ:     if (comp_reg == COMP_Z) state_next = ST_NSTART;
            ST_NSTART: state_next = ST_NWAIT;
            ST_NWAIT: begin
                if (norm_status.done) begin
                    state_next = (comp_reg == COMP_Z) ? ST_OUT : ST_NSTART;
                end
            end
            ST_OUT:    if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_ready    = 1'b0;
        mem_rd_en  = 1'b0;
        norm_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_READ:   mem_rd_en = (rd_idx_reg != RD_DONE);
            ST_NSTART: norm_start = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Component under work: magnitude for squaring and normalization.
    always_comb begin
        case (comp_reg)
            COMP_X:  mag_sel = x_reg[11] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
            COMP_Y:  mag_sel = MAG_W'(y_reg);
            default: mag_sel = z_reg[11] ? MAG_W'(-z_reg) : MAG_W'(z_reg);
        endcase
    end

    // Face sum of the gathered samples around the vertex.
    always_comb begin
        sum_x = 12'(vals_reg[RD_PREV_C]) - 12'(vals_reg[RD_PREV_CP]);
        sum_z = 12'(vals_reg[RD_PREV_C]) - 12'(cur_sample_reg);
        if (item_c1_reg) begin
            sum_x = sum_x + 12'(vals_reg[RD_PREV_CM]) - 12'(vals_reg[RD_PREV_C]);
            sum_z = sum_z + 12'(vals_reg[RD_PREV_CM]) - 12'(vals_reg[RD_CUR_CM]);
        end
        if (item_r2_reg) begin
            sum_x = sum_x + 12'(vals_reg[RD_PREV2_C]) - 12'(vals_reg[RD_PREV2_CP]);
            sum_z = sum_z + 12'(vals_reg[RD_PREV2_C]) - 12'(vals_reg[RD_PREV_C]);
            if (item_c1_reg) begin
                sum_x = sum_x + 12'(vals_reg[RD_PREV2_CM]) - 12'(vals_reg[RD_PREV2_C]);
                sum_z = sum_z + 12'(vals_reg[RD_PREV2_CM]) - 12'(vals_reg[RD_PREV_CM]);
            end
        end
    end

    // Item datapath: gather, face sum, sum of squares, result capture.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_col_reg   <= col_reg;
            item_row_reg   <= row_reg - RW'(1);
            item_slot_reg  <= slot_reg;
            item_c1_reg    <= (col_reg != '0);
            item_r2_reg    <= (row_reg >= RW'(2));
            cur_sample_reg <= s_height_sample;
            rd_idx_reg     <= '0;
        end
        if (state_reg == ST_READ) begin
            if (rd_idx_reg != RD_PREV_C) vals_reg[rd_idx_reg - 3'd1] <= mem_rd_data;
            if (rd_idx_reg != RD_DONE) rd_idx_reg <= rd_idx_reg + 3'd1;
        end
        if (state_reg == ST_SUM) begin
            x_reg    <= sum_x;
            z_reg    <= sum_z;
            y_reg    <= 6'd10 + (item_c1_reg ? 6'd10 : 6'd0) + (item_r2_reg ? 6'd10 : 6'd0)
                      + ((item_c1_reg && item_r2_reg) ? 6'd10 : 6'd0);
            s_reg    <= '0;
            comp_reg <= COMP_X;
        end
        if (state_reg == ST_SQ) begin
            s_reg    <= s_reg + SUMSQ_W'(mag_sel) * SUMSQ_W'(mag_sel);
            comp_reg <= (comp_reg == COMP_Z) ? COMP_X : comp_t'(comp_reg + 2'd1);
        end
        if (state_reg == ST_NWAIT && norm_status.done) begin
            case (comp_reg)
                COMP_X:  res_x_reg <= x_reg[11] ? -$signed(norm_status.result)
                                                : $signed(norm_status.result);
                COMP_Y:  res_y_reg <= norm_status.result[14:0];
                default: res_z_reg <= z_reg[11] ? -$signed(norm_status.result)
                                                : $signed(norm_status.result);
            endcase
            if (comp_reg != COMP_Z) comp_reg <= comp_t'(comp_reg + 2'd1);
        end
    end

    hvn_norm_unit u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .mag     (mag_sel),
        .sum_sq  (s_reg),
        .status  (norm_status)
    );

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_normal_x      <= res_x_reg;
            m_normal_y      <= res_y_reg;
            m_normal_z      <= res_z_reg;
            m_vertex_column <= COORD_W'(item_col_reg);
            m_vertex_row    <= COORD_W'(item_row_reg);
        end
    end

    assign m_valid = m_valid_reg;

    // A new output word is only loaded from the output state.
    a_out_from_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output word loaded outside the output state");

    // The normalizer is never started while it is still busy.
    a_norm_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_start |-> !norm_status.busy)
        else $error("normalizer started while busy");

    // The up component of a vertex normal is always positive.
    a_y_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_normal_y != 15'd0))
        else $error("zero up component on a normal");

    // Input is refused while an item is in work.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NWAIT) |-> !s_ready)
        else $error("input accepted during normalization");

endmodule
`default_nettype wire

FILE: hdl/hvn_line_store.sv
// Three-row sample store: one write port, one registered read port.
`default_nettype none
module hvn_line_store
    import hvn_pkg::*;
#(
    parameter int DEPTH = 3072
) (
    input  wire                          aclk,
    input  wire                          wr_en,
    input  wire [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire [SAMPLE_W-1:0]           wr_data,
    input  wire                          rd_en,
    input  wire [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [SAMPLE_W-1:0]          rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/hvn_norm_unit.sv
// Bit-serial unit computing round(16384*mag/sqrt(sum)), one result bit per square phase and compare phase.
`default_nettype none
module hvn_norm_unit
    import hvn_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   start,
    input  wire [MAG_W-1:0]       mag,
    input  wire [SUMSQ_W-1:0]     sum_sq,
    output norm_status_t          status
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 phase_reg;
    logic [3:0]           bit_reg;
    logic [UNIT_W-1:0]    k_reg;
    logic [31:0]          sq_reg;
    logic [21:0]          magsq_reg;
    logic [SUMSQ_W-1:0]   sum_reg;
    logic [UNIT_W-1:0]    cand;
    logic [53:0]          prod;
    logic [53:0]          target;
    logic [UNIT_W:0]      rounded;

    assign cand    = k_reg | (UNIT_W'(1) << bit_reg);
    assign prod    = 54'(sq_reg) * 54'(sum_reg);
    assign target  = {2'b00, magsq_reg, 30'd0};
    assign rounded = {1'b0, k_reg} + 17'd1;

    // Control: busy while bits remain, done pulses after the last bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            bit_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                bit_reg   <= 4'd15;
            end else if (busy_reg) begin
                phase_reg <= !phase_reg;
                if (phase_reg) begin
                    if (bit_reg == 4'd0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        bit_reg <= bit_reg - 4'd1;
                    end
                end
            end
        end
    end

    // Datapath: square the candidate, then compare candidate^2*sum with mag^2*2^30.
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            magsq_reg <= 22'(mag) * 22'(mag);
            sum_reg   <= sum_sq;
            k_reg     <= '0;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                sq_reg <= 32'(cand) * 32'(cand);
            end else if (prod <= target) begin
                k_reg <= cand;
            end
        end
    end

    assign status.busy   = busy_reg;
    assign status.done   = done_reg;
    assign status.result = rounded[UNIT_W:1];

endmodule
`default_nettype wire

FILE: tb/tb_heightmap_vertex_normals.sv
// Self-checking testbench for the heightmap vertex normal block.
`default_nettype none

module tb_heightmap_vertex_normals
    import hvn_pkg::*;
();

    // One predicted or observed normal word.
    typedef struct {
        logic signed [15:0] nx;
        logic [14:0]        ny;
        logic signed [15:0] nz;
        logic [9:0]         col;
        logic [9:0]         row;
    } normal_t;

    // Holds the predicted normals and compares them with the block's output.
    class normal_scoreboard;
        normal_t     pending_normals[$];
        logic [7:0]  heights[3][1024];
        int unsigned cur_col;
        int unsigned cur_row;
        int unsigned width_reg;
        int unsigned height_reg;
        int          error_count;
        int          normals_seen;

        function void reset_state();
            cur_col = 0;
            cur_row = 0;
            width_reg = 1024;
            height_reg = 1024;
            pending_normals.delete();
        endfunction

        function void set_width(int unsigned v);
            width_reg = v & 11'h7ff;
        endfunction

        function void set_height(int unsigned v);
            height_reg = v & 11'h7ff;
        endfunction

        static function int unsigned clamp(int unsigned v);
            if (v < 2) return 2;
            if (v > 1024) return 1024;
            return v;
        endfunction

        // Rounded 16384*mag/sqrt(s), ties away from zero, by bitwise search.
        static function longint unsigned unit_of(longint unsigned mag, longint unsigned s);
            longint unsigned t;
            longint unsigned goal;
            longint unsigned k;
            longint unsigned cand;
            t = mag * 32768;
            goal = t * t;
            k = 0;
            for (int b = 15; b >= 0; b--) begin
                cand = k | (64'd1 << b);
                if (cand * cand * s <= goal) k = cand;
            end
            return (k + 1) >> 1;
        endfunction

        static function logic [15:0] signed_unit(int v, longint unsigned s);
            longint unsigned m;
            m = unit_of(v < 0 ? -v : v, s);
            return v < 0 ? 16'(17'h10000 - m) : 16'(m);
        endfunction

        function void add_face(int s0, int s1, int unsigned c, ref int x, ref int y, ref int z);
            int h;
            h = heights[s0][c % 1024];
            x += h - int'(heights[s0][(c + 1) % 1024]);
            y += 10;
            z += h - int'(heights[s1][c % 1024]);
        endfunction

        // Notes an accepted sample and predicts the normal it releases, if any.
        function void note_sample(logic [7:0] hs);
            int unsigned w;
            int unsigned hg;
            int unsigned c;
            int unsigned r;
            int x;
            int y;
            int z;
            int sc;
            int sp;
            int sp2;
            longint unsigned s;
            normal_t n;
            w = clamp(width_reg);
            hg = clamp(height_reg);
            c = cur_col;
            r = cur_row;
            sc = r % 3;
            heights[sc][c % 1024] = hs;
            if (r >= 1 && c + 1 < w) begin
                sp = (r + 2) % 3;
                sp2 = (r + 1) % 3;
                x = 0;
                y = 0;
                z = 0;
                add_face(sp, sc, c, x, y, z);
                if (c >= 1) add_face(sp, sc, c - 1, x, y, z);
                if (r >= 2) begin
                    add_face(sp2, sp, c, x, y, z);
                    if (c >= 1) add_face(sp2, sp, c - 1, x, y, z);
                end
                s = longint'(x) * x + longint'(y) * y + longint'(z) * z;
                n.nx = signed_unit(x, s);
                n.ny = 15'(unit_of(y, s));
                n.nz = signed_unit(z, s);
                n.col = 10'(c);
                n.row = 10'(r - 1);
                pending_normals.push_back(n);
            end
            if (c + 1 >= w) begin
                cur_col = 0;
                cur_row = (r + 1 >= hg) ? 0 : r + 1;
            end else begin
                cur_col = c + 1;
            end
        endfunction

        // Compares one output word with the oldest prediction.
        function void check_normal(normal_t got);
            normal_t want;
            normals_seen++;
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected normal col %0d row %0d", $time, got.col, got.row);
                error_count++;
                return;
            end
            want = pending_normals.pop_front();
            if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                got.col !== want.col || got.row !== want.row) begin
                $display("%0t: mismatch expected (%0d %0d %0d @%0d,%0d) actual (%0d %0d %0d @%0d,%0d)",
                         $time, want.nx, want.ny, want.nz, want.col, want.row,
                         got.nx, got.ny, got.nz, got.col, got.row);
                error_count++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_index = CFG_MAP_WIDTH;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_height_sample = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_normal_x;
    logic [14:0]        m_normal_y;
    logic signed [15:0] m_normal_z;
    logic [9:0]         m_vertex_column;
    logic [9:0]         m_vertex_row;

    normal_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int samples_sent;
    int directed_count;

    heightmap_vertex_normals dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_height_sample(s_height_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z),
        .m_vertex_column(m_vertex_column), .m_vertex_row(m_vertex_row)
    );

    always #4 aclk = ~aclk;

    // Receiver: random back-pressure, with a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sample the output words at the rising edge.
    always @(posedge aclk) begin
        normal_t got;
        if (aresetn && m_valid && m_ready) begin
            got.nx = m_normal_x;
            got.ny = m_normal_y;
            got.nz = m_normal_z;
            got.col = m_vertex_column;
            got.row = m_vertex_row;
            board.check_normal(got);
        end
    end

    // Offers one sample, with a random idle gap first, and waits for acceptance.
    // Valid stays high after acceptance until the next idle gap or the next drain.
    task automatic send_sample(logic [7:0] hs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_height_sample <= hs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_sample(hs);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending_normals.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned v);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= CFG_W'(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MAP_WIDTH) board.set_width(v);
        else board.set_height(v);
        @(negedge aclk);
    endtask

    // A whole frame of random heights, biased toward the extremes now and then.
    task automatic send_frame(int unsigned w, int unsigned h);
        logic [7:0] v;
        for (int i = 0; i < w * h; i++) begin
            case ($urandom_range(3))
                0: v = $urandom_range(1) ? 8'hff : 8'h00;
                default: v = 8'($urandom_range(255));
            endcase
            send_sample(v);
        end
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        drain();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
    endtask

    initial begin
        board = new();
        board.reset_state();
        send_idle_pct = 26;
        recv_idle_pct = 62;
        hold_off = 0;
        samples_sent = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: smallest map and steepest slopes.
        set_size(2, 2);
        send_sample(8'h00); send_sample(8'hff); send_sample(8'hff); send_sample(8'h00);
        send_sample(8'h00); send_sample(8'h00); send_sample(8'hff); send_sample(8'hff);
        set_size(3, 4);
        for (int i = 0; i < 12; i++) send_sample(i[0] ? 8'hff : 8'h00);
        // Out-of-range sizes clamp: zero acts as two.
        set_size(0, 1);
        send_frame(2, 2);
        // The largest width code acts as the maximum, so these samples stay in row zero.
        set_size(2047, 2);
        for (int i = 0; i < 13; i++) send_sample(8'(i * 19));
        // A narrower width taken mid-row wraps at the next sample.
        set_size(5, 2);
        send_sample(8'h80);
        send_frame(5, 1);
        directed_count = samples_sent;

        // Random frames of small sizes.
        while (samples_sent < directed_count + 390) begin
            if (samples_sent > directed_count + 130 && send_idle_pct == 26) begin
                send_idle_pct = 62;
                recv_idle_pct = 26;
            end else if (samples_sent > directed_count + 260 && send_idle_pct == 62) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_size($urandom_range(2, 9), $urandom_range(2, 7));
            send_frame(board.clamp(board.width_reg), board.clamp(board.height_reg));
        end

        // Long receiver hold-off while the sender keeps offering samples.
        set_size(4, 4);
        fork
            begin
                hold_off = 1;
                repeat (600) @(negedge aclk);
                hold_off = 0;
            end
            send_frame(4, 4);
        join
        set_size(1024, 1024);
        drain();

        $display("Covered %0d samples and %0d normals over clamped, tiny and random map sizes,",
                 samples_sent, board.normals_seen);
        $display("with random stalls on both sides and a long output hold-off.");
        if (board.error_count == 0 && board.pending_normals.size() == 0) begin
            $display("tb_heightmap_vertex_normals passed");
        end else begin
            $display("tb_heightmap_vertex_normals failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20000000;
        $display("tb_heightmap_vertex_normals failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
hdl/hvn_pkg.sv
hdl/hvn_line_store.sv
hdl/hvn_norm_unit.sv
hdl/heightmap_vertex_normals.sv
tb/tb_heightmap_vertex_normals.sv
